FILE: rtl/ltc_pkg.sv
`default_nettype none
// ============================================================================
// ltc_pkg: shared types and constants of the literal token classifier
// Result codes, character constants, the per-token state record and the
// helper functions that pick the integer and floating-point types.
// ============================================================================
package ltc_pkg;

    localparam logic [2:0] COUNT_MAX = 3'd6;
    localparam logic [2:0] COUNT_ONE = 3'd1;
    localparam logic [2:0] COUNT_TRUE_LEN = 3'd4;
    localparam logic [2:0] COUNT_FALSE_LEN = 3'd5;

    typedef enum logic [3:0] {
        LT_NONE       = 4'd0,
        LT_BOOL       = 4'd1,
        LT_CHAR       = 4'd2,
        LT_CHAR8      = 4'd3,
        LT_CHAR16     = 4'd4,
        LT_CHAR32     = 4'd5,
        LT_WCHAR      = 4'd6,
        LT_INT        = 4'd7,
        LT_UINT       = 4'd8,
        LT_LONG       = 4'd9,
        LT_ULONG      = 4'd10,
        LT_LONGLONG   = 4'd11,
        LT_ULONGLONG  = 4'd12,
        LT_FLOAT      = 4'd13,
        LT_DOUBLE     = 4'd14,
        LT_LONGDOUBLE = 4'd15
    } t_lit_type;

    typedef enum logic [2:0] {
        LB_NA      = 3'd0,
        LB_BINARY  = 3'd1,
        LB_OCTAL   = 3'd2,
        LB_DECIMAL = 3'd3,
        LB_HEX     = 3'd4
    } t_lit_base;

    // ASCII codes the classifier compares against.
    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_EIGHT = 8'h38;
    localparam logic [7:0] CH_UP_B  = 8'h42;
    localparam logic [7:0] CH_UP_E  = 8'h45;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_UP_L  = 8'h4C;
    localparam logic [7:0] CH_UP_P  = 8'h50;
    localparam logic [7:0] CH_UP_U  = 8'h55;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_B  = 8'h62;
    localparam logic [7:0] CH_LO_E  = 8'h65;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_LO_L  = 8'h6C;
    localparam logic [7:0] CH_LO_P  = 8'h70;
    localparam logic [7:0] CH_LO_R  = 8'h72;
    localparam logic [7:0] CH_LO_S  = 8'h73;
    localparam logic [7:0] CH_LO_T  = 8'h74;
    localparam logic [7:0] CH_LO_U  = 8'h75;
    localparam logic [7:0] CH_LO_X  = 8'h78;

    typedef struct packed {
        logic [2:0] char_count;
        logic [7:0] first_char;
        logic [7:0] second_char;
        logic [7:0] previous_char;
        logic       seen_double_ell;
        logic       seen_unsigned_mark;
        logic       seen_ell;
        logic       seen_dot_or_exponent;
        logic       seen_binary_exponent;
        logic       matches_true_word;
        logic       matches_false_word;
    } t_ltc_state;

    localparam t_ltc_state STATE_RESET = '{
        char_count:           3'd0,
        first_char:           8'h00,
        second_char:          8'h00,
        previous_char:        8'h00,
        seen_double_ell:      1'b0,
        seen_unsigned_mark:   1'b0,
        seen_ell:             1'b0,
        seen_dot_or_exponent: 1'b0,
        seen_binary_exponent: 1'b0,
        matches_true_word:    1'b1,
        matches_false_word:   1'b1
    };

    typedef struct packed {
        t_lit_type lit_type;
        t_lit_base lit_base;
    } t_ltc_result;

    function automatic logic [7:0] true_char(input logic [1:0] idx);
        logic [7:0] ch;
        unique case (idx)
            2'd0:    ch = CH_LO_T;
            2'd1:    ch = CH_LO_R;
            2'd2:    ch = CH_LO_U;
            default: ch = CH_LO_E;
        endcase
        return ch;
    endfunction

    // Positions past the word length never reach the compare.
    function automatic logic [7:0] false_char(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = CH_LO_F;
            3'd1:    ch = CH_LO_A;
            3'd2:    ch = CH_LO_L;
            3'd3:    ch = CH_LO_S;
            3'd4:    ch = CH_LO_E;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic t_lit_type int_type(input t_ltc_state s);
        t_lit_type t;
        if (s.seen_double_ell) begin
            t = s.seen_unsigned_mark ? LT_ULONGLONG : LT_LONGLONG;
        end else if (s.seen_ell) begin
            t = s.seen_unsigned_mark ? LT_ULONG : LT_LONG;
        end else begin
            t = s.seen_unsigned_mark ? LT_UINT : LT_INT;
        end
        return t;
    endfunction

    function automatic t_lit_type float_type(input logic [7:0] last_char);
        t_lit_type t;
        if (last_char == CH_LO_F || last_char == CH_UP_F) begin
            t = LT_FLOAT;
        end else if (last_char == CH_LO_L || last_char == CH_UP_L) begin
            t = LT_LONGDOUBLE;
        end else begin
            t = LT_DOUBLE;
        end
        return t;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/ltc_step.sv
`default_nettype none
// ============================================================================
// ltc_step: one character step of the literal token classifier
// Folds one character into the token state and, on the token's last
// character, decides the literal's type and base.
// ============================================================================
module ltc_step (
    input  wire ltc_pkg::t_ltc_state  i_state,
    input  wire logic [7:0]           i_char_code,
    input  wire logic                 i_is_last,
    output ltc_pkg::t_ltc_state       o_next_state,
    output ltc_pkg::t_ltc_result      o_result
);

    ltc_pkg::t_ltc_state  upd;
    logic [2:0]           pos;
    logic                 pair_ll;

    assign pos = i_state.char_count;
    assign pair_ll = (i_state.previous_char == ltc_pkg::CH_UP_L && i_char_code == ltc_pkg::CH_UP_L)
                  || (i_state.previous_char == ltc_pkg::CH_LO_L && i_char_code == ltc_pkg::CH_LO_L);

    always_comb begin
        upd = i_state;
        if (pos == 3'd0) begin
            upd.first_char = i_char_code;
        end
        if (pos == 3'd1) begin
            upd.second_char = i_char_code;
        end
        if (pos != 3'd0 && pair_ll) begin
            upd.seen_double_ell = 1'b1;
        end
        if (i_char_code == ltc_pkg::CH_LO_U || i_char_code == ltc_pkg::CH_UP_U) begin
            upd.seen_unsigned_mark = 1'b1;
        end
        if (i_char_code == ltc_pkg::CH_LO_L || i_char_code == ltc_pkg::CH_UP_L) begin
            upd.seen_ell = 1'b1;
        end
        if (i_char_code == ltc_pkg::CH_DOT || i_char_code == ltc_pkg::CH_LO_E
                || i_char_code == ltc_pkg::CH_UP_E) begin
            upd.seen_dot_or_exponent = 1'b1;
        end
        if (i_char_code == ltc_pkg::CH_LO_P || i_char_code == ltc_pkg::CH_UP_P) begin
            upd.seen_binary_exponent = 1'b1;
        end
        if (pos >= ltc_pkg::COUNT_TRUE_LEN
                || ltc_pkg::true_char(pos[1:0]) != i_char_code) begin
            upd.matches_true_word = 1'b0;
        end
        if (pos >= ltc_pkg::COUNT_FALSE_LEN || ltc_pkg::false_char(pos) != i_char_code) begin
            upd.matches_false_word = 1'b0;
        end
        upd.previous_char = i_char_code;
        if (pos < ltc_pkg::COUNT_MAX) begin
            upd.char_count = pos + 3'd1;
        end
    end

    // The decision looks at the state with the last character already folded in.
    always_comb begin
        o_result.lit_type = ltc_pkg::LT_NONE;
        o_result.lit_base = ltc_pkg::LB_NA;
        priority if (upd.char_count <= ltc_pkg::COUNT_ONE) begin
            o_result.lit_type = ltc_pkg::LT_INT;
            o_result.lit_base = ltc_pkg::LB_DECIMAL;
        end else if (upd.first_char == ltc_pkg::CH_QUOTE) begin
            o_result.lit_type = ltc_pkg::LT_CHAR;
        end else if ((upd.matches_true_word && upd.char_count == ltc_pkg::COUNT_TRUE_LEN)
                || (upd.matches_false_word && upd.char_count == ltc_pkg::COUNT_FALSE_LEN)) begin
            o_result.lit_type = ltc_pkg::LT_BOOL;
        end else if (upd.second_char == ltc_pkg::CH_QUOTE) begin
            unique case (upd.first_char)
                ltc_pkg::CH_LO_U: o_result.lit_type = ltc_pkg::LT_CHAR16;
                ltc_pkg::CH_UP_U: o_result.lit_type = ltc_pkg::LT_CHAR32;
                ltc_pkg::CH_UP_L: o_result.lit_type = ltc_pkg::LT_WCHAR;
                default:          o_result.lit_type = ltc_pkg::LT_NONE;
            endcase
        end else if (upd.second_char == ltc_pkg::CH_EIGHT
                && upd.first_char == ltc_pkg::CH_LO_U) begin
            o_result.lit_type = ltc_pkg::LT_CHAR8;
        end else if (upd.second_char == ltc_pkg::CH_LO_B
                || upd.second_char == ltc_pkg::CH_UP_B) begin
            o_result.lit_type = ltc_pkg::int_type(upd);
            o_result.lit_base = ltc_pkg::LB_BINARY;
        end else if (upd.second_char == ltc_pkg::CH_LO_X
                || upd.second_char == ltc_pkg::CH_UP_X) begin
            o_result.lit_type = upd.seen_binary_exponent ? ltc_pkg::float_type(i_char_code)
                                                         : ltc_pkg::int_type(upd);
            o_result.lit_base = ltc_pkg::LB_HEX;
        end else if (upd.seen_dot_or_exponent) begin
            o_result.lit_type = ltc_pkg::float_type(i_char_code);
            o_result.lit_base = ltc_pkg::LB_DECIMAL;
        end else if (upd.first_char == ltc_pkg::CH_ZERO) begin
            o_result.lit_type = ltc_pkg::int_type(upd);
            o_result.lit_base = ltc_pkg::LB_OCTAL;
        end else begin
            o_result.lit_type = ltc_pkg::int_type(upd);
            o_result.lit_base = ltc_pkg::LB_DECIMAL;
        end
    end

    // The state starts over after the token's last character.
    assign o_next_state = i_is_last ? ltc_pkg::STATE_RESET : upd;

endmodule
`default_nettype wire

FILE: rtl/literal_token_classifier.sv
`default_nettype none
// ============================================================================
// literal_token_classifier: type and base of a literal token
// Takes a literal token one character per transaction and gives the
// literal's type and base as one result transaction on its last character.
// ============================================================================
//
//  channel | valid       | stall        | payload
//  --------+-------------+--------------+----------------------------------
//  input   | i_in_valid  | o_in_stall   | i_char_code, i_is_last
//  output  | o_out_valid | i_out_stall  | o_literal_type, o_literal_base
//
//  One character per cycle unless the input is stalled; the result shows in
//  the cycle after the last character is taken, in a single result register.
//  The token state sits in flip-flops and is updated by one short pass of
//  compare logic per character.
//  Synchronous reset clears the token state and the result valid.
//  The input is stalled only while a result waits and the output is stalled.
//
module literal_token_classifier (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_char_code,
    input  wire logic       i_is_last,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [3:0]      o_literal_type,
    output logic [2:0]      o_literal_base
);

    ltc_pkg::t_ltc_state  r_state;
    ltc_pkg::t_ltc_state  n_state;
    ltc_pkg::t_ltc_result step_result;
    ltc_pkg::t_ltc_result r_result;
    logic                 r_out_valid;
    logic                 in_accept;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    ltc_step u_step (
        .i_state      (r_state),
        .i_char_code  (i_char_code),
        .i_is_last    (i_is_last),
        .o_next_state (n_state),
        .o_result     (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ltc_pkg::STATE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_state <= n_state;
            end
            if (in_accept && i_is_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && i_is_last) begin
            r_result <= step_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_literal_type = r_result.lit_type;
    assign o_literal_base = r_result.lit_base;

endmodule
`default_nettype wire

FILE: rtl/ltc_checker.sv
`default_nettype none
// ============================================================================
// ltc_checker: port-level checks of the literal token classifier
// Watches the top-level ports for result timing and result consistency.
// ============================================================================
module ltc_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_stall,
    input wire logic       i_is_last,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [3:0] o_literal_type,
    input wire logic [2:0] o_literal_base
);

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    // A stalled result keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_literal_type)
            && $stable(o_literal_base))
        else $error("result changed while stalled");

    // The last character of a token produces a result in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_is_last |=> o_out_valid)
        else $error("no result after the last character");

    // Other characters produce nothing once any pending result has left.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !i_is_last && !(o_out_valid && i_out_stall) |=> !o_out_valid)
        else $error("result without a last character");

    // Input is held back only behind a stalled result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a waiting result");

    // Binary literals are always integer types.
    a_binary_int: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_literal_base == ltc_pkg::LB_BINARY |->
            o_literal_type == ltc_pkg::LT_INT || o_literal_type == ltc_pkg::LT_UINT
            || o_literal_type == ltc_pkg::LT_LONG || o_literal_type == ltc_pkg::LT_ULONG
            || o_literal_type == ltc_pkg::LT_LONGLONG
            || o_literal_type == ltc_pkg::LT_ULONGLONG)
        else $error("binary literal with a non-integer type");

endmodule

bind literal_token_classifier ltc_checker u_ltc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .i_is_last      (i_is_last),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_literal_type (o_literal_type),
    .o_literal_base (o_literal_base)
);
`default_nettype wire
